// ----- hw/rtl/qisd_pkg.sv -----
package qisd_pkg;

  // Deepest supported image: side 2^MAX_LOG2
  localparam int MAX_LOG2    = 10;
  localparam int LOG_W       = 4;                 // holds 0..MAX_LOG2
  localparam int STK_DEPTH   = MAX_LOG2;          // one quadrant per tree level
  localparam int STK_IDX_W   = $clog2(STK_DEPTH);
  localparam int POS_W       = 10;
  localparam int SIDE_W      = 11;

  // Stream tags
  localparam logic [7:0] TAG_LEAF  = 8'h30;
  localparam logic [7:0] TAG_SPLIT = 8'h31;

  // Result kinds
  localparam logic [1:0] KIND_FILL     = 2'd0;
  localparam logic [1:0] KIND_UNKNOWN  = 2'd1;
  localparam logic [1:0] KIND_SPLIT1   = 2'd2;
  localparam logic [1:0] KIND_CLAMPED  = 2'd3;

  // Quadrant codes, visited in this order
  localparam logic [1:0] QUAD_NW = 2'd0;
  localparam logic [1:0] QUAD_NE = 2'd1;
  localparam logic [1:0] QUAD_SW = 2'd2;
  localparam logic [1:0] QUAD_SE = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TAG    = 2'd1,
    PH_COLOUR = 2'd2
  } phase_t;

  typedef logic [1:0] quad_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [SIDE_W-1:0] square_side;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic              image_done;
  } result_t;

  // Outcome of moving to the next node in preorder
  typedef struct packed {
    logic                 done;    // whole tree finished
    logic [STK_IDX_W-1:0] idx;     // stack entry that advances
    logic [LOG_W-1:0]     level;   // new tree level
    quad_t                quad;    // new quadrant at that level
    logic [POS_W-1:0]     x;
    logic [POS_W-1:0]     y;
  } unwind_t;

endpackage

// ----- hw/rtl/qisd_if.sv -----
// Compressed byte stream channel
interface qisd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

// Decoded command channel
interface qisd_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  logic [qisd_pkg::POS_W-1:0]      pos_x;
  logic [qisd_pkg::POS_W-1:0]      pos_y;
  logic [qisd_pkg::SIDE_W-1:0]     square_side;
  logic [7:0]                      red;
  logic [7:0]                      green;
  logic [7:0]                      blue;
  logic [7:0]                      alpha;
  logic                            image_done;

  modport source (output valid, output kind, output pos_x, output pos_y,
                  output square_side, output red, output green, output blue,
                  output alpha, output image_done, input ready);
  modport sink   (input valid, input kind, input pos_x, input pos_y,
                  input square_side, input red, input green, input blue,
                  input alpha, input image_done, output ready);
endinterface

// ----- hw/rtl/qisd_unwind.sv -----
// Next-node search: pops finished levels (quadrant SE) and steps the
// deepest level that still has a quadrant left. Position bits below that
// level are cleared, then the level's own x and y bits are set to match the new quadrant.
module qisd_unwind (
  input  logic [qisd_pkg::LOG_W-1:0]  log_side,
  input  logic [qisd_pkg::LOG_W-1:0]  level,
  input  qisd_pkg::quad_t             stack [qisd_pkg::STK_DEPTH],
  input  logic [qisd_pkg::POS_W-1:0]  cur_x,
  input  logic [qisd_pkg::POS_W-1:0]  cur_y,
  output qisd_pkg::unwind_t           uw
);

  logic                              found;
  logic [qisd_pkg::STK_IDX_W-1:0]    sel;
  logic [qisd_pkg::LOG_W-1:0]        sel_level;
  logic [qisd_pkg::LOG_W-1:0]        sh;
  logic [qisd_pkg::POS_W-1:0]        bit_l;
  logic [qisd_pkg::POS_W-1:0]        x_clr;
  logic [qisd_pkg::POS_W-1:0]        y_clr;
  qisd_pkg::quad_t                   q;

  // Priority search: deepest live level whose quadrant is not the last
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < qisd_pkg::STK_DEPTH; i++) begin
      if ((qisd_pkg::LOG_W'(i) < level) && (stack[i] != qisd_pkg::QUAD_SE)) begin
        found = 1'b1;
        sel   = qisd_pkg::STK_IDX_W'(i);
      end
    end
  end

  assign sel_level = qisd_pkg::LOG_W'(sel) + qisd_pkg::LOG_W'(1);
  assign sh        = log_side - sel_level;
  assign bit_l     = qisd_pkg::POS_W'(1) << sh;
  assign x_clr     = cur_x & ~(bit_l - qisd_pkg::POS_W'(1));
  assign y_clr     = cur_y & ~(bit_l - qisd_pkg::POS_W'(1));
  assign q         = stack[sel];

  // Step to the next quadrant at the selected level
  always_comb begin
    uw.done  = !found;
    uw.idx   = sel;
    uw.level = sel_level;
    uw.quad  = q + 2'd1;
    uw.x     = x_clr;
    uw.y     = y_clr;
    unique case (q)
      qisd_pkg::QUAD_NW: uw.x = x_clr | bit_l;
      qisd_pkg::QUAD_NE: begin
        uw.x = x_clr & ~bit_l;
        uw.y = y_clr | bit_l;
      end
      qisd_pkg::QUAD_SW: begin
        uw.x = x_clr | bit_l;
        uw.y = y_clr | bit_l;
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/qisd_core.sv -----
// Decoder state: header, tag and colour phases, walk position and the
// quadrant stack. One byte is consumed per accept.
module qisd_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic [7:0]           byte_in,
  output logic                 res_vld,
  output qisd_pkg::result_t    res
);

  qisd_pkg::phase_t                 phase_r, phase_nxt;
  logic [1:0]                       cnt_r, cnt_nxt;
  logic [23:0]                      rgb_r, rgb_nxt;
  logic [qisd_pkg::LOG_W-1:0]       ils_r, ils_nxt;
  logic [qisd_pkg::LOG_W-1:0]       level_r, level_nxt;
  logic [qisd_pkg::POS_W-1:0]       x_r, x_nxt;
  logic [qisd_pkg::POS_W-1:0]       y_r, y_nxt;
  qisd_pkg::quad_t                  stack_r [qisd_pkg::STK_DEPTH];

  logic                             stk_we;
  logic [qisd_pkg::STK_IDX_W-1:0]   stk_idx;
  qisd_pkg::quad_t                  stk_wd;
  logic [qisd_pkg::SIDE_W-1:0]      side;
  qisd_pkg::unwind_t                uw;

  qisd_unwind u_unwind (
    .log_side (ils_r),
    .level    (level_r),
    .stack    (stack_r),
    .cur_x    (x_r),
    .cur_y    (y_r),
    .uw       (uw)
  );

  assign side = qisd_pkg::SIDE_W'(1) << (ils_r - level_r);

  // Step logic for one byte
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    rgb_nxt   = rgb_r;
    ils_nxt   = ils_r;
    level_nxt = level_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    stk_we    = 1'b0;
    stk_idx   = level_r[qisd_pkg::STK_IDX_W-1:0];
    stk_wd    = qisd_pkg::QUAD_NW;
    res_vld   = 1'b0;
    res       = '0;
    res.pos_x = x_r;
    res.pos_y = y_r;
    res.square_side = side;

    unique case (phase_r)
      qisd_pkg::PH_HEADER: begin
        level_nxt = '0;
        x_nxt     = '0;
        y_nxt     = '0;
        cnt_nxt   = '0;
        rgb_nxt   = '0;
        phase_nxt = qisd_pkg::PH_TAG;
        if (byte_in > 8'(qisd_pkg::MAX_LOG2)) begin
          ils_nxt         = qisd_pkg::LOG_W'(qisd_pkg::MAX_LOG2);
          res_vld         = 1'b1;
          res.kind        = qisd_pkg::KIND_CLAMPED;
          res.pos_x       = '0;
          res.pos_y       = '0;
          res.square_side = qisd_pkg::SIDE_W'(1) << qisd_pkg::MAX_LOG2;
        end else begin
          ils_nxt = byte_in[qisd_pkg::LOG_W-1:0];
        end
      end

      qisd_pkg::PH_COLOUR: begin
        if (cnt_r != 2'd3) begin
          rgb_nxt = {rgb_r[15:0], byte_in};
          cnt_nxt = cnt_r + 2'd1;
        end else begin
          cnt_nxt        = '0;
          phase_nxt      = qisd_pkg::PH_TAG;
          res_vld        = 1'b1;
          res.kind       = qisd_pkg::KIND_FILL;
          res.red        = rgb_r[23:16];
          res.green      = rgb_r[15:8];
          res.blue       = rgb_r[7:0];
          res.alpha      = byte_in;
          res.image_done = uw.done;
        end
      end

      default: begin
        phase_nxt = qisd_pkg::PH_TAG;
        if (byte_in == qisd_pkg::TAG_LEAF) begin
          phase_nxt = qisd_pkg::PH_COLOUR;
          cnt_nxt   = '0;
          rgb_nxt   = '0;
        end else if (byte_in == qisd_pkg::TAG_SPLIT && level_r < ils_r) begin
          // descend into the NW quadrant
          level_nxt = level_r + qisd_pkg::LOG_W'(1);
          stk_we    = 1'b1;
        end else begin
          res_vld        = 1'b1;
          res.kind       = (byte_in == qisd_pkg::TAG_SPLIT) ? qisd_pkg::KIND_SPLIT1
                                                            : qisd_pkg::KIND_UNKNOWN;
          res.image_done = uw.done;
        end
      end
    endcase

    // Leaving a finished node: next node in preorder, or end of tree
    if (res_vld && phase_r != qisd_pkg::PH_HEADER) begin
      if (uw.done) begin
        phase_nxt = qisd_pkg::PH_HEADER;
      end else begin
        level_nxt = uw.level;
        x_nxt     = uw.x;
        y_nxt     = uw.y;
        stk_we    = 1'b1;
        stk_idx   = uw.idx;
        stk_wd    = uw.quad;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= qisd_pkg::PH_HEADER;
      cnt_r   <= '0;
      rgb_r   <= '0;
      ils_r   <= '0;
      level_r <= '0;
      x_r     <= '0;
      y_r     <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      rgb_r   <= rgb_nxt;
      ils_r   <= ils_nxt;
      level_r <= level_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
    end
  end

  // Quadrant stack; entries above the current level are never read
  always_ff @(posedge clk) begin
    if (acc && stk_we) begin
      stack_r[stk_idx] <= stk_wd;
    end
  end

  a_level_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= ils_r)
    else $error("tree level deeper than image");

  a_log_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    ils_r <= qisd_pkg::LOG_W'(qisd_pkg::MAX_LOG2))
    else $error("image log side above maximum");

  a_done_to_header: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res_vld && res.image_done) |=> phase_r == qisd_pkg::PH_HEADER)
    else $error("tree finished but header not expected");

  a_header_resets_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && phase_r == qisd_pkg::PH_HEADER) |=>
      (level_r == '0 && x_r == '0 && y_r == '0))
    else $error("walk not restarted after header");

endmodule

// ----- hw/rtl/qisd_out_reg.sv -----
// Result register: holds one command until the sink takes it; the
// upstream side keeps flowing while the register drains in the same cycle.
module qisd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  qisd_pkg::result_t   res,
  output logic                up_ready,
  qisd_out_if.source          out_ch
);

  logic              vld_r;
  qisd_pkg::result_t data_r;

  assign up_ready = !vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_ch.valid       = vld_r;
  assign out_ch.kind        = data_r.kind;
  assign out_ch.pos_x       = data_r.pos_x;
  assign out_ch.pos_y       = data_r.pos_y;
  assign out_ch.square_side = data_r.square_side;
  assign out_ch.red         = data_r.red;
  assign out_ch.green       = data_r.green;
  assign out_ch.blue        = data_r.blue;
  assign out_ch.alpha       = data_r.alpha;
  assign out_ch.image_done  = data_r.image_done;

endmodule

// ----- hw/rtl/quadtree_image_stream_decoder.sv -----
// Quadtree image stream decoder.
// in_ch carries the compressed stream one byte per item: a header byte with
// log2 of the image side, then the preorder tree (tag 0x31 split, tag 0x30
// followed by R,G,B,A, any other tag skipped). out_ch carries one command
// per finished square: fill, unknown tag, split at side one, or clamped
// header; image_done marks the command that closes the tree, after which
// the next byte is taken as a new header.
// Throughput: one byte per cycle while the receiver keeps up, with or without a result.
// A result is registered and on out_ch in the cycle after the byte that
// causes it. The next-node search is a combinational priority pick over
// the ten quadrant stack levels.
// Reset (rst_n low, synchronous) empties the result register and leaves the
// decoder expecting a header byte.
// When the receiver stalls, the held result stays on out_ch and in_ch.ready
// drops until that result is taken; a result taken in a cycle lets a new
// byte in during the same cycle.
module quadtree_image_stream_decoder (
  input  logic          clk,
  input  logic          rst_n,
  qisd_in_if.sink       in_ch,
  qisd_out_if.source    out_ch
);

  logic              acc;
  logic              up_ready;
  logic              res_vld;
  qisd_pkg::result_t res;

  assign in_ch.ready = up_ready;
  assign acc         = in_ch.valid && up_ready;

  qisd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .byte_in (in_ch.byte_in),
    .res_vld (res_vld),
    .res     (res)
  );

  qisd_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (acc && res_vld),
    .res      (res),
    .up_ready (up_ready),
    .out_ch   (out_ch)
  );

endmodule
